[src/assert_macros.svh]
// Assertion macros shared by the circular record log index RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/crli_pkg.sv]
// Types and constants of the circular record log index.
// Used by crli_ctrl, crli_addr and circular_record_log_index_core; no dependencies.
package crli_pkg;

  // request kinds
  localparam logic [2:0] KIND_APPEND = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_READ   = 3'd2;
  localparam logic [2:0] KIND_RESET  = 3'd3;
  localparam logic [2:0] KIND_ERASE  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_START  = 3'd0;
  localparam logic [2:0] CFG_OFFSET = 3'd1;
  localparam logic [2:0] CFG_SIZE   = 3'd2;
  localparam logic [2:0] CFG_COUNT  = 3'd3;
  localparam logic [2:0] CFG_OVER   = 3'd4;

  // configuration reset values
  localparam logic [31:0] RST_START  = 32'd0;
  localparam logic [15:0] RST_OFFSET = 16'd4;
  localparam logic [15:0] RST_SIZE   = 16'd16;
  localparam logic [15:0] RST_COUNT  = 16'd64;
  localparam logic        RST_OVER   = 1'b1;

  localparam logic [15:0] BLANK_INDEX = 16'hFFFF;
  localparam logic [15:0] FIRST_ID    = 16'd1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_UNREAD = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] record_number;
  } in_t;

  typedef struct packed {
    logic        ok;
    status_t     status;
    logic [31:0] record_address;
    logic [31:0] crc_address;
    logic [15:0] record_count;
    logic [15:0] first_record;
    logic [15:0] last_record;
  } out_t;

  typedef struct packed {
    logic [31:0] area_start_address;
    logic [15:0] first_record_offset;
    logic [15:0] record_size;
    logic [15:0] number_of_records;
    logic        overwritable;
  } cfg_t;

  // index stage result handed to the address stages
  typedef struct packed {
    logic        ok;
    status_t     status;
    logic        has_addr;
    logic [15:0] target;
    logic [15:0] record_count;
    logic [15:0] first_record;
    logic [15:0] last_record;
  } ctl_res_t;

endpackage

[src/circular_record_log_index_core.sv]
// Circular record log index: a request passes through the input register, index stage,
// product stage and result register in that order.
// Throughput 1 request per cycle; the only loop is the index/wrapped state update,
// done within the index stage. Rate is held only by out_stall.
// Synchronous active-low reset: blank log (index 0xFFFF, not wrapped), pipeline
// empty, configuration registers back to their defaults.
`include "assert_macros.svh"

module circular_record_log_index_core #(
  parameter int CRC_BYTES = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  crli_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output crli_pkg::out_t   out_data
);

  crli_pkg::cfg_t     cfg_r;
  crli_pkg::in_t      req_r;
  crli_pkg::ctl_res_t ctl_res;
  logic               v1_r, v2_r, v3_r, v4_r;
  logic               en1, en2, en3, en4;

  // Configuration registers: the user must write them only while idle (not enforced here); no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.area_start_address  <= crli_pkg::RST_START;
      cfg_r.first_record_offset <= crli_pkg::RST_OFFSET;
      cfg_r.record_size         <= crli_pkg::RST_SIZE;
      cfg_r.number_of_records   <= crli_pkg::RST_COUNT;
      cfg_r.overwritable        <= crli_pkg::RST_OVER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crli_pkg::CFG_START:  cfg_r.area_start_address  <= cfg_wdata;
        crli_pkg::CFG_OFFSET: cfg_r.first_record_offset <= cfg_wdata[15:0];
        crli_pkg::CFG_SIZE:   cfg_r.record_size         <= cfg_wdata[15:0];
        crli_pkg::CFG_COUNT:  cfg_r.number_of_records   <= cfg_wdata[15:0];
        crli_pkg::CFG_OVER:   cfg_r.overwritable        <= cfg_wdata[0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // Each stage advances when it is empty or the stage after it advances.
  assign en4      = !v4_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Hold the request in the input register.
  always_ff @(posedge clk) begin
    if (en1) begin
      req_r <= in_data;
    end
  end

  // Index stage: the state advances as the request moves on.
  crli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (v1_r),
    .req       (req_r),
    .load      (en2),
    .res_r     (ctl_res)
  );

  // Address stages: product, then sums into the result register.
  crli_addr #(
    .CRC_BYTES (CRC_BYTES)
  ) u_addr (
    .clk      (clk),
    .cfg      (cfg_r),
    .ctl      (ctl_res),
    .load_mul (en3),
    .load_out (en4),
    .out_r    (out_data)
  );

  assign out_valid = v4_r;

  `ASSERT_IMPLIES(a_reject_no_addr, clk, rst_n,
    out_valid && !out_data.ok,
    (out_data.record_address == 32'd0) && (out_data.crc_address == 32'd0),
    "rejected request carries an address")
  `ASSERT_IMPLIES(a_ok_status, clk, rst_n,
    out_valid,
    out_data.ok == (out_data.status == crli_pkg::ST_OK),
    "ok flag disagrees with status")
  `ASSERT_IMPLIES(a_stall_full, clk, rst_n,
    in_stall,
    v1_r && v2_r && v3_r && v4_r && out_stall,
    "input stalled while the pipeline has room")
  `ASSERT_IMPLIES(a_count_bound, clk, rst_n,
    out_valid && (out_data.last_record == 16'd0),
    (out_data.record_count == 16'd0),
    "records counted with no newest record")

endmodule

[src/crli_ctrl.sv]
// Index state (current record, wrapped flag) and request decode.
// Depends on crli_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crli_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  crli_pkg::cfg_t     cfg,
  input  logic               req_valid,
  input  crli_pkg::in_t      req,
  input  logic               load,
  output crli_pkg::ctl_res_t res_r
);

  logic [15:0]        ci_r, ci_nxt;
  logic               wr_r, wr_nxt;
  crli_pkg::ctl_res_t res_nxt;
  logic               in_range;
  logic [15:0]        rc;
  logic [15:0]        rec;
  logic               idx_valid;

  assign rc  = cfg.number_of_records;
  assign rec = req.record_number;

  always_comb begin
    ci_nxt           = ci_r;
    wr_nxt           = wr_r;
    res_nxt          = '0;
    res_nxt.ok       = 1'b1;
    res_nxt.status   = crli_pkg::ST_OK;
    in_range         = (rec != 16'd0) && (rec <= rc);
    unique case (req.kind)
      crli_pkg::KIND_APPEND: begin
        if (rc <= ci_r) begin
          if (ci_r == crli_pkg::BLANK_INDEX) begin
            ci_nxt = crli_pkg::FIRST_ID;
            wr_nxt = 1'b0;
          end else if (cfg.overwritable) begin
            ci_nxt = crli_pkg::FIRST_ID;
            wr_nxt = 1'b1;
          end else begin
            res_nxt.ok     = 1'b0;
            res_nxt.status = crli_pkg::ST_FULL;
          end
        end else begin
          ci_nxt = ci_r + 16'd1;
        end
        res_nxt.target   = ci_nxt;
        res_nxt.has_addr = res_nxt.ok;
      end
      crli_pkg::KIND_WRITE: begin
        if (!in_range) begin
          res_nxt.ok     = 1'b0;
          res_nxt.status = crli_pkg::ST_RANGE;
        end else begin
          if (ci_r == crli_pkg::BLANK_INDEX) begin
            wr_nxt = 1'b0;
          end else if (rec < ci_r) begin
            wr_nxt = 1'b1;
          end
          ci_nxt           = rec;
          res_nxt.target   = rec;
          res_nxt.has_addr = 1'b1;
        end
      end
      crli_pkg::KIND_READ: begin
        if (!in_range) begin
          res_nxt.ok     = 1'b0;
          res_nxt.status = crli_pkg::ST_RANGE;
        end else if ((ci_r > rc) || ((ci_r < rec) && !(cfg.overwritable && wr_r))) begin
          res_nxt.ok     = 1'b0;
          res_nxt.status = crli_pkg::ST_UNREAD;
        end else begin
          res_nxt.target   = rec;
          res_nxt.has_addr = 1'b1;
        end
      end
      crli_pkg::KIND_RESET: begin
        ci_nxt = crli_pkg::BLANK_INDEX;
        wr_nxt = 1'b0;
      end
      crli_pkg::KIND_ERASE: begin
        if (!in_range) begin
          res_nxt.ok     = 1'b0;
          res_nxt.status = crli_pkg::ST_RANGE;
        end else begin
          res_nxt.target   = rec;
          res_nxt.has_addr = 1'b1;
        end
      end
      default: begin
        res_nxt.ok     = 1'b0;
        res_nxt.status = crli_pkg::ST_RANGE;
      end
    endcase

    // log summary after the step
    idx_valid = (ci_nxt != crli_pkg::BLANK_INDEX) && (ci_nxt <= rc);
    if (!idx_valid) begin
      res_nxt.record_count = 16'd0;
    end else if (wr_nxt && cfg.overwritable) begin
      res_nxt.record_count = rc;
    end else begin
      res_nxt.record_count = ci_nxt;
    end
    res_nxt.last_record = idx_valid ? ci_nxt : 16'd0;
    if ((ci_nxt != 16'd0) && !wr_nxt && (ci_nxt != crli_pkg::BLANK_INDEX)) begin
      res_nxt.first_record = crli_pkg::FIRST_ID;
    end else if (wr_nxt && cfg.overwritable && (rc > ci_nxt)) begin
      res_nxt.first_record = ci_nxt + 16'd1;
    end else if (wr_nxt && cfg.overwritable && (rc == ci_nxt)) begin
      res_nxt.first_record = crli_pkg::FIRST_ID;
    end else begin
      res_nxt.first_record = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r <= crli_pkg::BLANK_INDEX;
      wr_r <= 1'b0;
    end else if (load && req_valid) begin
      ci_r <= ci_nxt;
      wr_r <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  `ASSERT_NEXT(a_reset_blanks, clk, rst_n,
    load && req_valid && (req.kind == crli_pkg::KIND_RESET),
    (ci_r == crli_pkg::BLANK_INDEX) && !wr_r && (res_r.record_count == 16'd0),
    "reset log did not leave a blank index")
  `ASSERT_NEXT(a_reject_holds, clk, rst_n,
    load && req_valid && !res_nxt.ok,
    $stable(ci_r) && $stable(wr_r),
    "rejected request changed the index")

endmodule

[src/crli_addr.sv]
// Address pipeline: slot offset product, then payload and CRC address sums.
// Depends on crli_pkg.
module crli_addr #(
  parameter int CRC_BYTES = 2
) (
  input  logic               clk,
  input  crli_pkg::cfg_t     cfg,
  input  crli_pkg::ctl_res_t ctl,
  input  logic               load_mul,
  input  logic               load_out,
  output crli_pkg::out_t     out_r
);

  logic [16:0]        stride;
  logic [15:0]        idx_m1;
  logic [32:0]        prod_full;
  logic [31:0]        prod_r;
  logic [31:0]        base_r;
  logic [31:0]        crc_base_r;
  crli_pkg::ctl_res_t ctl_r;
  logic [31:0]        rec_addr;
  logic [31:0]        crc_addr;

  assign stride    = {1'b0, cfg.record_size} + 17'(CRC_BYTES);
  assign idx_m1    = ctl.target - 16'd1;
  assign prod_full = idx_m1 * stride;

  // stage one: product and the two base addresses
  always_ff @(posedge clk) begin
    if (load_mul) begin
      prod_r     <= prod_full[31:0];
      base_r     <= cfg.area_start_address + {16'd0, cfg.first_record_offset};
      crc_base_r <= cfg.area_start_address + {16'd0, cfg.first_record_offset}
                    + {16'd0, cfg.record_size};
      ctl_r      <= ctl;
    end
  end

  assign rec_addr = ctl_r.has_addr ? (base_r + prod_r) : 32'd0;
  assign crc_addr = ctl_r.has_addr ? (crc_base_r + prod_r) : 32'd0;

  // stage two: final sums into the result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.ok             <= ctl_r.ok;
      out_r.status         <= ctl_r.status;
      out_r.record_address <= rec_addr;
      out_r.crc_address    <= crc_addr;
      out_r.record_count   <= ctl_r.record_count;
      out_r.first_record   <= ctl_r.first_record;
      out_r.last_record    <= ctl_r.last_record;
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench for circular_record_log_index_core: drives log requests, predicts each result
// from its own copy of the log index and area registers, and checks every result.
// Depends on crli_pkg and the core RTL.
module tb;

  localparam int CRC_BYTES = 2;
  localparam int LONG_HOLD = 60;      // receiver hold-off long enough to back up the pipe
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES = 10;    // extra wait after the drain before the final check
  // request kinds the block does not define; they must be rejected
  localparam logic [2:0] KIND_SPARE5 = 3'd5;
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [2:0]      cfg_index = crli_pkg::CFG_START;
  logic [31:0]     cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  crli_pkg::in_t   in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  crli_pkg::out_t  out_data;

  circular_record_log_index_core #(.CRC_BYTES(CRC_BYTES)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Shadow of the log index and the area registers
  logic [15:0]     log_index = crli_pkg::BLANK_INDEX;
  logic            log_wrapped = 1'b0;
  crli_pkg::cfg_t  area_cfg = '{crli_pkg::RST_START, crli_pkg::RST_OFFSET, crli_pkg::RST_SIZE,
                                crli_pkg::RST_COUNT, crli_pkg::RST_OVER};

  crli_pkg::out_t index_reports_due[$];   // predicted results, oldest first

  int  n_requests = 0;
  int  n_checked = 0;
  int  n_errors = 0;
  int  n_settings = 0;
  int  cycle_cnt = 0;
  bit  calm = 1'b0;             // no random idling on either side
  int  hold_reqs = 0;           // bumped by a test to ask for one long receiver hold-off
  int  hold_seen = 0;
  int  hold_cnt = 0;
  int  stall_left = 0;

  // Slot id of the oldest record, given the current index and settings.
  function automatic logic [15:0] oldest_id();
    if (log_index > 16'd0 && !log_wrapped && log_index < crli_pkg::BLANK_INDEX)
      return crli_pkg::FIRST_ID;
    if (log_wrapped && area_cfg.overwritable) begin
      if (area_cfg.number_of_records > log_index) return log_index + 16'd1;
      if (area_cfg.number_of_records == log_index) return crli_pkg::FIRST_ID;
    end
    return 16'd0;
  endfunction

  // Apply one request to the shadow index and return the result it should produce.
  function automatic crli_pkg::out_t advance_log_index(crli_pkg::in_t req);
    crli_pkg::out_t res;
    logic           has_addr;
    logic [15:0]    tgt;
    logic           in_range;
    logic           index_bad;
    logic [31:0]    stride;
    res = '0;
    res.ok = 1'b1;
    res.status = crli_pkg::ST_OK;
    has_addr = 1'b0;
    tgt = '0;
    in_range = (req.record_number != 16'd0) &&
               (req.record_number <= area_cfg.number_of_records);
    case (req.kind)
      crli_pkg::KIND_APPEND: begin
        if (area_cfg.number_of_records <= log_index) begin
          if (log_index == crli_pkg::BLANK_INDEX) begin
            log_index = crli_pkg::FIRST_ID;
            log_wrapped = 1'b0;
          end else if (area_cfg.overwritable) begin
            log_index = crli_pkg::FIRST_ID;
            log_wrapped = 1'b1;
          end else begin
            res.ok = 1'b0;
            res.status = crli_pkg::ST_FULL;
          end
        end else begin
          log_index = log_index + 16'd1;
        end
        if (res.ok) begin
          tgt = log_index;
          has_addr = 1'b1;
        end
      end
      crli_pkg::KIND_WRITE: begin
        if (!in_range) begin
          res.ok = 1'b0;
          res.status = crli_pkg::ST_RANGE;
        end else begin
          // going back below the current record means the log has wrapped
          if (log_index == crli_pkg::BLANK_INDEX) log_wrapped = 1'b0;
          else if (req.record_number < log_index) log_wrapped = 1'b1;
          log_index = req.record_number;
          tgt = req.record_number;
          has_addr = 1'b1;
        end
      end
      crli_pkg::KIND_READ: begin
        if (!in_range) begin
          res.ok = 1'b0;
          res.status = crli_pkg::ST_RANGE;
        end else if (log_index > area_cfg.number_of_records ||
                     (log_index < req.record_number &&
                      !(area_cfg.overwritable && log_wrapped))) begin
          res.ok = 1'b0;
          res.status = crli_pkg::ST_UNREAD;
        end else begin
          tgt = req.record_number;
          has_addr = 1'b1;
        end
      end
      crli_pkg::KIND_RESET: begin
        log_index = crli_pkg::BLANK_INDEX;
        log_wrapped = 1'b0;
      end
      crli_pkg::KIND_ERASE: begin
        if (!in_range) begin
          res.ok = 1'b0;
          res.status = crli_pkg::ST_RANGE;
        end else begin
          tgt = req.record_number;
          has_addr = 1'b1;
        end
      end
      default: begin
        res.ok = 1'b0;
        res.status = crli_pkg::ST_RANGE;
      end
    endcase
    if (has_addr) begin
      stride = 32'(area_cfg.record_size) + 32'(CRC_BYTES);
      res.record_address = area_cfg.area_start_address +
                           32'(area_cfg.first_record_offset) + 32'(tgt - 16'd1) * stride;
      res.crc_address = res.record_address + 32'(area_cfg.record_size);
    end
    index_bad = (log_index == crli_pkg::BLANK_INDEX) ||
                (log_index > area_cfg.number_of_records);
    if (index_bad) res.record_count = '0;
    else if (log_wrapped && area_cfg.overwritable) res.record_count = area_cfg.number_of_records;
    else res.record_count = log_index;
    res.first_record = oldest_id();
    res.last_record = index_bad ? 16'd0 : log_index;
    return res;
  endfunction

  // Offer one request; hold it until accepted, then queue its predicted result.
  task automatic send_req(input logic [2:0] kind, input logic [15:0] rec);
    int             gap;
    crli_pkg::in_t  req;
    req.kind = kind;
    req.record_number = rec;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    index_reports_due.push_back(advance_log_index(req));
    n_requests++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (index_reports_due.size() != 0) @(posedge clk);
  endtask

  // Write one area register; only call with the block drained.
  task automatic set_area_reg(input logic [2:0] which, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (which)
      crli_pkg::CFG_START:  area_cfg.area_start_address = value;
      crli_pkg::CFG_OFFSET: area_cfg.first_record_offset = value[15:0];
      crli_pkg::CFG_SIZE:   area_cfg.record_size = value[15:0];
      crli_pkg::CFG_COUNT:  area_cfg.number_of_records = value[15:0];
      crli_pkg::CFG_OVER:   area_cfg.overwritable = value[0];
      default: ;
    endcase
  endtask

  task automatic set_area(input logic [31:0] start, input logic [15:0] offset,
                          input logic [15:0] size, input logic [15:0] slots,
                          input logic over);
    wait_drained();
    set_area_reg(crli_pkg::CFG_START, start);
    set_area_reg(crli_pkg::CFG_OFFSET, 32'(offset));
    set_area_reg(crli_pkg::CFG_SIZE, 32'(size));
    set_area_reg(crli_pkg::CFG_COUNT, 32'(slots));
    set_area_reg(crli_pkg::CFG_OVER, 32'(over));
    n_settings++;
  endtask

  // One random request: appends most often, mostly in-range record ids, some noise.
  task automatic send_random_req();
    int          pick;
    logic [15:0] rec;
    pick = $urandom_range(0, 99);
    rec = 16'($urandom_range(0, int'(area_cfg.number_of_records) + 1));
    if (pick < 45) send_req(crli_pkg::KIND_APPEND, 16'($urandom));
    else if (pick < 65) send_req(crli_pkg::KIND_WRITE, rec);
    else if (pick < 83) send_req(crli_pkg::KIND_READ, rec);
    else if (pick < 90) send_req(crli_pkg::KIND_ERASE, rec);
    else if (pick < 94) send_req(crli_pkg::KIND_RESET, 16'($urandom));
    else send_req(3'($urandom_range(0, 7)), 16'($urandom));
  endtask

  // Default area: every kind, the record-number extremes and the undefined kinds.
  task automatic test_basic_ops();
    send_req(crli_pkg::KIND_APPEND, 16'd0);       // blank log starts at record 1
    send_req(crli_pkg::KIND_APPEND, 16'd0);
    send_req(crli_pkg::KIND_READ, 16'd2);
    send_req(crli_pkg::KIND_READ, 16'd3);         // past the index, not wrapped
    send_req(crli_pkg::KIND_READ, 16'd0);
    send_req(crli_pkg::KIND_READ, 16'd65);
    send_req(crli_pkg::KIND_WRITE, 16'd64);
    send_req(crli_pkg::KIND_APPEND, 16'd0);       // full and overwritable: wrap
    send_req(crli_pkg::KIND_READ, 16'd64);
    send_req(crli_pkg::KIND_ERASE, 16'd0);
    send_req(crli_pkg::KIND_ERASE, 16'd64);
    send_req(crli_pkg::KIND_ERASE, 16'hFFFF);
    send_req(crli_pkg::KIND_WRITE, 16'd0);
    send_req(crli_pkg::KIND_WRITE, 16'hFFFF);
    send_req(KIND_SPARE5, 16'd1);
    send_req(KIND_SPARE6, 16'hFFFF);
    send_req(KIND_SPARE7, 16'd0);
    send_req(crli_pkg::KIND_RESET, 16'hFFFF);
    send_req(crli_pkg::KIND_READ, 16'd1);         // blank log is never readable
    send_req(crli_pkg::KIND_ERASE, 16'd1);
    send_req(crli_pkg::KIND_WRITE, 16'd5);        // blank log takes the record unwrapped
    send_req(crli_pkg::KIND_WRITE, 16'd3);        // lower record marks the log wrapped
    send_req(crli_pkg::KIND_RESET, 16'd0);
  endtask

  // Full log that may not be overwritten, then tiny areas.
  task automatic test_protected_log();
    set_area(32'h0000_1000, 16'd8, 16'd32, 16'd3, 1'b0);
    send_req(crli_pkg::KIND_RESET, 16'd0);
    repeat (4) send_req(crli_pkg::KIND_APPEND, 16'd0);   // last one is rejected
    send_req(crli_pkg::KIND_READ, 16'd3);
    send_req(crli_pkg::KIND_WRITE, 16'd1);
    send_req(crli_pkg::KIND_READ, 16'd3);
    wait_drained();
    set_area_reg(crli_pkg::CFG_OVER, 32'd1);
    send_req(crli_pkg::KIND_READ, 16'd3);
    send_req(crli_pkg::KIND_APPEND, 16'd0);
    wait_drained();
    set_area_reg(crli_pkg::CFG_COUNT, 32'd1);
    send_req(crli_pkg::KIND_RESET, 16'd0);
    send_req(crli_pkg::KIND_APPEND, 16'd0);
    send_req(crli_pkg::KIND_APPEND, 16'd0);
  endtask

  // Shrink the area under a live index so that it points past the last slot.
  task automatic test_shrunk_area();
    set_area(crli_pkg::RST_START, crli_pkg::RST_OFFSET, crli_pkg::RST_SIZE, 16'd64, 1'b1);
    send_req(crli_pkg::KIND_RESET, 16'd0);
    send_req(crli_pkg::KIND_WRITE, 16'd50);
    send_req(crli_pkg::KIND_WRITE, 16'd20);
    send_req(crli_pkg::KIND_WRITE, 16'd40);
    wait_drained();
    set_area_reg(crli_pkg::CFG_COUNT, 32'd10);
    send_req(crli_pkg::KIND_READ, 16'd5);
    send_req(crli_pkg::KIND_ERASE, 16'd10);
    send_req(crli_pkg::KIND_APPEND, 16'd0);
    wait_drained();
    set_area_reg(crli_pkg::CFG_COUNT, 32'd64);
    send_req(crli_pkg::KIND_RESET, 16'd0);
    send_req(crli_pkg::KIND_WRITE, 16'd30);
    wait_drained();
    set_area_reg(crli_pkg::CFG_COUNT, 32'd16);
    send_req(crli_pkg::KIND_READ, 16'd1);
    send_req(crli_pkg::KIND_APPEND, 16'd0);
    wait_drained();
    set_area_reg(crli_pkg::CFG_OVER, 32'd0);
    send_req(crli_pkg::KIND_WRITE, 16'd16);
    send_req(crli_pkg::KIND_APPEND, 16'd0);
    send_req(crli_pkg::KIND_READ, 16'd16);
  endtask

  // Register extremes: addresses wrap past 2^32.
  task automatic test_address_wrap();
    set_area(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd65534, 1'b1);
    send_req(crli_pkg::KIND_RESET, 16'd0);
    send_req(crli_pkg::KIND_WRITE, 16'd65534);
    send_req(crli_pkg::KIND_READ, 16'd65534);
    send_req(crli_pkg::KIND_APPEND, 16'd0);
    send_req(crli_pkg::KIND_ERASE, 16'd65534);
    send_req(crli_pkg::KIND_READ, 16'hFFFF);
    send_req(crli_pkg::KIND_APPEND, 16'd0);
    set_area(32'd0, 16'd0, 16'd1, 16'd65534, 1'b1);
    send_req(crli_pkg::KIND_ERASE, 16'd1);
    send_req(crli_pkg::KIND_WRITE, 16'd65534);
    send_req(crli_pkg::KIND_APPEND, 16'd0);
  endtask

  // Hold the result side off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    set_area(32'h2000_0000, 16'd4, 16'd16, 16'd8, 1'b1);
    hold_reqs++;
    repeat (40) send_random_req();
  endtask

  // Random phases, each with its own area settings; the last one runs without idling.
  task automatic test_random_phases();
    int   p;
    int   pick;
    logic [31:0] start;
    logic [15:0] offset;
    logic [15:0] size;
    logic [15:0] slots;
    for (p = 0; p < 8; p++) begin
      pick = $urandom_range(0, 9);
      start = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? 32'd0 : $urandom;
      pick = $urandom_range(0, 9);
      offset = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd0 : 16'($urandom_range(0, 256));
      pick = $urandom_range(0, 9);
      size = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd1 : 16'($urandom_range(1, 64));
      pick = $urandom_range(0, 9);
      if (pick == 0) slots = 16'd65534 - 16'($urandom_range(0, 1));
      else if (pick == 1) slots = 16'($urandom_range(1, 1000));
      else slots = 16'($urandom_range(1, 20));
      set_area(start, offset, size, slots, 1'($urandom));
      calm = (p == 7);
      repeat (125) send_random_req();
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off when a test asks.
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin : check_reports
    crli_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (index_reports_due.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        n_errors++;
      end else begin
        want = index_reports_due.pop_front();
        n_checked++;
        if (out_data.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_data.ok);
          n_errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          n_errors++;
        end
        if (out_data.record_address !== want.record_address) begin
          $error("record_address: expected %h, got %h",
                 want.record_address, out_data.record_address);
          n_errors++;
        end
        if (out_data.crc_address !== want.crc_address) begin
          $error("crc_address: expected %h, got %h", want.crc_address, out_data.crc_address);
          n_errors++;
        end
        if (out_data.record_count !== want.record_count) begin
          $error("record_count: expected %0d, got %0d",
                 want.record_count, out_data.record_count);
          n_errors++;
        end
        if (out_data.first_record !== want.first_record) begin
          $error("first_record: expected %0d, got %0d",
                 want.first_record, out_data.first_record);
          n_errors++;
        end
        if (out_data.last_record !== want.last_record) begin
          $error("last_record: expected %0d, got %0d", want.last_record, out_data.last_record);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_protected_log();
    test_shrunk_area();
    test_address_wrap();
    test_backpressure();
    test_random_phases();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (index_reports_due.size() != 0) begin
      $error("%0d results never arrived", index_reports_due.size());
      n_errors++;
    end
    $display("covered %0d log requests over %0d area settings, %0d results checked",
             n_requests, n_settings + 1, n_checked);
    if (n_errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/crli_pkg.sv
src/crli_ctrl.sv
src/crli_addr.sv
src/circular_record_log_index_core.sv
tb/tb.sv
